// ===== sv/qdh_pkg.sv =====
// Shared types and constants of the quality delta histogram.
// No dependencies.
`timescale 1ns / 1ps

package qdh_pkg;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_SYMBOL = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_FINAL  = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_SYMBOL = 2'd1,
        ST_IGNORED    = 2'd2,
        ST_STICKY     = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_LINE_LIMIT = 1'b0,
        CFG_LIMIT_EN   = 1'b1
    } cfg_reg_t;

    localparam logic [7:0] TOP_SYMBOL  = 8'd93;
    localparam int         LINE_W      = 32;
    localparam int         OUT_W       = 32;
    localparam int         MAPVAL_W    = 6;
    localparam int         OUTQ_DEPTH  = 4;

    // Control word travelling from the front end to the histogram stages
    typedef struct packed {
        logic              valid;
        logic              bump_first;
        logic              bump_diff;
        logic              bump_escape;
        logic              rd_req;
        logic              rd_sel;
        logic [7:0]        rd_index;
        status_t           status;
        logic [LINE_W-1:0] lines;
    } stage_ctl_t;

    typedef struct packed {
        logic [OUT_W-1:0]  count;
        status_t           status;
        logic [LINE_W-1:0] lines;
    } result_t;

endpackage

// ===== sv/qdh_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module qdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/qdh_front.sv =====
// Front end: config registers, line/error control, reduction map lookup.
// Depends on qdh_pkg and qdh_ram.
`timescale 1ns / 1ps

module qdh_front import qdh_pkg::*; #(
    parameter int MAP_DEPTH     = 64,
    parameter int SYMBOL_OFFSET = 33
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_take,
    input  logic [1:0]          s_func,
    input  logic [7:0]          s_symbol,
    input  logic [5:0]          s_map_value,
    input  logic                s_line_start,
    input  logic                s_table_select,
    input  logic [7:0]          s_read_index,
    output stage_ctl_t          s1_ctl,
    output logic [MAPVAL_W-1:0] s1_map_val
);

    localparam int MAP_AW = $clog2(MAP_DEPTH);

    logic [31:0]       line_limit_reg;
    logic              limit_en_reg;
    logic [LINE_W-1:0] line_counter_reg, line_counter_next;
    logic              line_active_reg, line_active_next;
    logic              error_seen_reg, error_seen_next;
    stage_ctl_t        s1_ctl_reg, s1_ctl_next;

    logic [8:0] map_idx;
    logic       sym_bad;
    logic       limit_hit;
    logic       map_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_limit_reg <= '0;
            limit_en_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LINE_LIMIT: line_limit_reg <= cfg_wdata;
                CFG_LIMIT_EN:   limit_en_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign map_idx   = {1'b0, s_symbol} - 9'(SYMBOL_OFFSET);
    assign sym_bad   = (s_symbol < 8'(SYMBOL_OFFSET)) || (s_symbol > TOP_SYMBOL)
                       || (map_idx >= 9'(MAP_DEPTH));
    assign limit_hit = limit_en_reg && (line_counter_reg >= line_limit_reg);

    always_comb begin
        line_counter_next       = line_counter_reg;
        line_active_next        = line_active_reg;
        error_seen_next         = error_seen_reg;
        s1_ctl_next             = '0;
        s1_ctl_next.valid       = in_take;
        s1_ctl_next.rd_sel      = s_table_select;
        s1_ctl_next.rd_index    = s_read_index;
        s1_ctl_next.status      = error_seen_reg ? ST_STICKY : ST_OK;
        if (in_take) begin
            case (func_t'(s_func))
                FUNC_SYMBOL: begin
                    if (error_seen_reg) begin
                        s1_ctl_next.status = ST_STICKY;
                    end else if (s_line_start) begin
                        line_active_next = 1'b0;
                        if (limit_hit) begin
                            s1_ctl_next.status = ST_IGNORED;
                        end else if (sym_bad) begin
                            s1_ctl_next.status = ST_BAD_SYMBOL;
                            error_seen_next    = 1'b1;
                        end else begin
                            line_active_next       = 1'b1;
                            s1_ctl_next.bump_first = 1'b1;
                            if (line_counter_reg != '1) begin
                                line_counter_next = line_counter_reg + LINE_W'(1);
                            end
                        end
                    end else if (!line_active_reg) begin
                        s1_ctl_next.status = ST_IGNORED;
                    end else if (sym_bad) begin
                        s1_ctl_next.status = ST_BAD_SYMBOL;
                        error_seen_next    = 1'b1;
                        line_active_next   = 1'b0;
                    end else begin
                        s1_ctl_next.bump_diff = 1'b1;
                    end
                end
                FUNC_READ: s1_ctl_next.rd_req = 1'b1;
                FUNC_FINAL: begin
                    line_active_next        = 1'b0;
                    s1_ctl_next.bump_escape = limit_en_reg && !error_seen_reg;
                end
                default: ; // map loads touch only the map
            endcase
        end
        s1_ctl_next.lines = line_counter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_counter_reg <= '0;
            line_active_reg  <= 1'b0;
            error_seen_reg   <= 1'b0;
            s1_ctl_reg.valid <= 1'b0;
        end else begin
            line_counter_reg <= line_counter_next;
            line_active_reg  <= line_active_next;
            error_seen_reg   <= error_seen_next;
            s1_ctl_reg       <= s1_ctl_next;
        end
    end

    assign map_we = in_take && (func_t'(s_func) == FUNC_LOAD)
                    && ({1'b0, s_symbol} < 9'(MAP_DEPTH));

    qdh_ram #(
        .WIDTH (MAPVAL_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (s_symbol[MAP_AW-1:0]),
        .wdata (s_map_value),
        .raddr (map_idx[MAP_AW-1:0]),
        .rdata (s1_map_val)
    );

    assign s1_ctl = s1_ctl_reg;

    // once raised, the error flag only falls through reset
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        error_seen_reg |=> error_seen_reg)
        else $error("error flag cleared without reset");

endmodule

// ===== sv/qdh_hist.sv =====
// Histogram stages: bin folding, read-modify-write of both count memories,
// clearing sweep after reset. Depends on qdh_pkg and qdh_ram.
`timescale 1ns / 1ps

module qdh_hist import qdh_pkg::*; #(
    parameter int HIST_DEPTH  = 256,
    parameter int ESCAPE_BIN  = 255,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  stage_ctl_t          s1_ctl,
    input  logic [MAPVAL_W-1:0] s1_map_val,
    output logic                clr_busy,
    output logic                s2_valid,
    output result_t             s2_res
);

    localparam int   HA     = $clog2(HIST_DEPTH);
    localparam int   CW     = COUNT_WIDTH;
    localparam logic ESC_OK = (ESCAPE_BIN < HIST_DEPTH);
    localparam logic [HA-1:0] ESC_ADDR  = HA'(ESCAPE_BIN);
    localparam logic [HA-1:0] LAST_ADDR = HA'(HIST_DEPTH - 1);

    // stage 1
    logic [MAPVAL_W-1:0] prev_value_reg;
    logic                val_ge;
    logic [MAPVAL_W-1:0] delta;
    logic [7:0]          bin;
    logic [HA-1:0]       first_raddr, diff_raddr;
    logic                rd_ok;

    // stage 2
    stage_ctl_t    s2_ctl_reg;
    logic [HA-1:0] s2_first_addr_reg, s2_diff_addr_reg;
    logic          s2_rd_ok_reg;
    logic [CW-1:0] first_rdata, diff_rdata;
    logic [CW-1:0] first_cur, diff_cur, first_inc, diff_inc, sel_cnt;
    logic [OUT_W-1:0] clamped;
    logic          first_we, diff_we;

    // last write of each memory, for a read issued in the same cycle
    logic          fwd_first_vld_reg, fwd_diff_vld_reg;
    logic [HA-1:0] fwd_first_addr_reg, fwd_diff_addr_reg;
    logic [CW-1:0] fwd_first_data_reg, fwd_diff_data_reg;

    // clearing sweep
    logic          clr_busy_reg;
    logic [HA-1:0] clr_addr_reg;

    // fold: (d+1)*2 for d >= 0, else (-d*2)|1
    assign val_ge = s1_map_val >= prev_value_reg;
    assign delta  = val_ge ? (s1_map_val - prev_value_reg) : (prev_value_reg - s1_map_val);
    assign bin    = val_ge ? {({1'b0, delta} + 7'd1), 1'b0} : {1'b0, delta, 1'b1};

    assign rd_ok  = s1_ctl.rd_req && ({3'b000, s1_ctl.rd_index} < 11'(HIST_DEPTH));

    always_comb begin
        if (s1_ctl.bump_first) begin
            first_raddr = HA'(s1_map_val);
        end else if (s1_ctl.bump_escape) begin
            first_raddr = ESC_ADDR;
        end else begin
            first_raddr = HA'(s1_ctl.rd_index);
        end
        if (s1_ctl.bump_diff) begin
            diff_raddr = HA'(bin);
        end else if (s1_ctl.bump_escape) begin
            diff_raddr = ESC_ADDR;
        end else begin
            diff_raddr = HA'(s1_ctl.rd_index);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_value_reg   <= '0;
            s2_ctl_reg.valid <= 1'b0;
        end else begin
            if (s1_ctl.valid && (s1_ctl.bump_first || s1_ctl.bump_diff)) begin
                prev_value_reg <= s1_map_val;
            end
            s2_ctl_reg <= s1_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        s2_first_addr_reg <= first_raddr;
        s2_diff_addr_reg  <= diff_raddr;
        s2_rd_ok_reg      <= rd_ok;
    end

    assign first_cur = (fwd_first_vld_reg && (fwd_first_addr_reg == s2_first_addr_reg))
                       ? fwd_first_data_reg : first_rdata;
    assign diff_cur  = (fwd_diff_vld_reg && (fwd_diff_addr_reg == s2_diff_addr_reg))
                       ? fwd_diff_data_reg : diff_rdata;

    assign first_inc = (&first_cur) ? first_cur : first_cur + CW'(1);
    assign diff_inc  = (&diff_cur)  ? diff_cur  : diff_cur  + CW'(1);

    assign first_we = s2_ctl_reg.valid
                      && (s2_ctl_reg.bump_first || (s2_ctl_reg.bump_escape && ESC_OK));
    assign diff_we  = s2_ctl_reg.valid
                      && (s2_ctl_reg.bump_diff || (s2_ctl_reg.bump_escape && ESC_OK));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_first_vld_reg <= 1'b0;
            fwd_diff_vld_reg  <= 1'b0;
        end else begin
            fwd_first_vld_reg <= first_we;
            fwd_diff_vld_reg  <= diff_we;
        end
        fwd_first_addr_reg <= s2_first_addr_reg;
        fwd_first_data_reg <= first_inc;
        fwd_diff_addr_reg  <= s2_diff_addr_reg;
        fwd_diff_data_reg  <= diff_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + HA'(1);
            end
        end
    end

    qdh_ram #(
        .WIDTH (CW),
        .DEPTH (HIST_DEPTH)
    ) u_first_ram (
        .aclk  (aclk),
        .we    (clr_busy_reg || first_we),
        .waddr (clr_busy_reg ? clr_addr_reg : s2_first_addr_reg),
        .wdata (clr_busy_reg ? '0 : first_inc),
        .raddr (first_raddr),
        .rdata (first_rdata)
    );

    qdh_ram #(
        .WIDTH (CW),
        .DEPTH (HIST_DEPTH)
    ) u_diff_ram (
        .aclk  (aclk),
        .we    (clr_busy_reg || diff_we),
        .waddr (clr_busy_reg ? clr_addr_reg : s2_diff_addr_reg),
        .wdata (clr_busy_reg ? '0 : diff_inc),
        .raddr (diff_raddr),
        .rdata (diff_rdata)
    );

    assign sel_cnt = s2_ctl_reg.rd_sel ? diff_cur : first_cur;

    generate
        if (CW > OUT_W) begin : g_clamp
            assign clamped = (|sel_cnt[CW-1:OUT_W]) ? '1 : sel_cnt[OUT_W-1:0];
        end else begin : g_pad
            assign clamped = OUT_W'(sel_cnt);
        end
    endgenerate

    assign s2_res.count  = s2_rd_ok_reg ? clamped : '0;
    assign s2_res.status = s2_ctl_reg.status;
    assign s2_res.lines  = s2_ctl_reg.lines;
    assign s2_valid      = s2_ctl_reg.valid;
    assign clr_busy      = clr_busy_reg;

    // no request may enter while the sweep owns the write ports
    a_no_item_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s1_ctl.valid)
        else $error("request entered during clearing sweep");

    // a request does at most one kind of memory work
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_ctl_reg.valid |-> $onehot0({s2_ctl_reg.bump_first, s2_ctl_reg.bump_diff,
                                        s2_ctl_reg.bump_escape, s2_ctl_reg.rd_req}))
        else $error("request carries conflicting actions");

endmodule

// ===== sv/qdh_outq.sv =====
// Result queue between the histogram stages and the output channel.
// Depends on qdh_pkg.
`timescale 1ns / 1ps

module qdh_outq import qdh_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res,
    output logic [2:0] occupancy
);

    result_t    slots [OUTQ_DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        case ({in_valid, pop})
            2'b10:   count_next = count_reg + 3'd1;
            2'b01:   count_next = count_reg - 3'd1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (in_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            slots[wr_ptr_reg] <= in_res;
        end
    end

    assign out_res   = slots[rd_ptr_reg];
    assign occupancy = count_reg;

    // credit accounting upstream must keep a free slot for every arrival
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> (count_reg != 3'(OUTQ_DEPTH)))
        else $error("result queue overflow");

endmodule

// ===== sv/quality_delta_histogram.sv =====
// Quality delta histogram, top level. Depends on qdh_pkg, qdh_front, qdh_hist, qdh_outq.
// Throughput: one request per cycle, sustained, while results are taken.
// An accepted request passes the map read, then the count read, before its result is
// offered; the count write-back shares the edge that queues the result.
// Reset: synchronous; after aresetn rises both histograms are swept to zero, one bin per
// cycle; no request is taken during the sweep (config writes still are).
`timescale 1ns / 1ps

module quality_delta_histogram import qdh_pkg::*; #(
    parameter int MAP_DEPTH     = 64,
    parameter int HIST_DEPTH    = 256,
    parameter int SYMBOL_OFFSET = 33,
    parameter int ESCAPE_BIN    = 255,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_symbol,
    input  logic [5:0]  s_map_value,
    input  logic        s_line_start,
    input  logic        s_table_select,
    input  logic [7:0]  s_read_index,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_count,
    output logic [1:0]  m_status,
    output logic [31:0] m_lines_counted
);

    stage_ctl_t          s1_ctl;
    logic [MAPVAL_W-1:0] s1_map_val;
    logic                clr_busy;
    logic                s2_valid;
    result_t             s2_res;
    result_t             out_res;
    logic [2:0]          occupancy;
    logic [3:0]          credit_sum;
    logic                in_take;

    // Every request yields exactly one result. A request is taken only when the
    // result queue has a slot for it after all requests still in the two
    // memory stages have landed, so the stages never stall and the memories'
    // read data never has to be held.
    assign credit_sum = 4'(occupancy) + 4'(s1_ctl.valid) + 4'(s2_valid);
    assign s_ready    = !clr_busy && (credit_sum < 4'(OUTQ_DEPTH));
    assign in_take    = s_valid && s_ready;

    // Stage 0: line and error bookkeeping is settled here at acceptance, as it
    // never depends on memory contents; the map is written or read here too.
    qdh_front #(
        .MAP_DEPTH     (MAP_DEPTH),
        .SYMBOL_OFFSET (SYMBOL_OFFSET)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_take        (in_take),
        .s_func         (s_func),
        .s_symbol       (s_symbol),
        .s_map_value    (s_map_value),
        .s_line_start   (s_line_start),
        .s_table_select (s_table_select),
        .s_read_index   (s_read_index),
        .s1_ctl         (s1_ctl),
        .s1_map_val     (s1_map_val)
    );

    // Stages 1 and 2: fold against the previous value, read the bins, then
    // increment and write back. Back-to-back hits on one bin are forwarded
    // from the last write.
    qdh_hist #(
        .HIST_DEPTH  (HIST_DEPTH),
        .ESCAPE_BIN  (ESCAPE_BIN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s1_ctl     (s1_ctl),
        .s1_map_val (s1_map_val),
        .clr_busy   (clr_busy),
        .s2_valid   (s2_valid),
        .s2_res     (s2_res)
    );

    // Results wait here, so new requests still flow while the sink stalls, until all queue slots are claimed.
    qdh_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_res    (s2_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res),
        .occupancy (occupancy)
    );

    assign m_count         = out_res.count;
    assign m_status        = out_res.status;
    assign m_lines_counted = out_res.lines;

    // queued plus in-flight requests never exceed the queue's slots
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_sum <= 4'(OUTQ_DEPTH))
        else $error("more requests in flight than result slots");

    // an accepted request shows up in stage 1 on the next cycle
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> s1_ctl.valid)
        else $error("accepted request lost before stage 1");

endmodule
